### rtl/b32h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32h_pkg
// shared types, constants and the symbol to ascii mapping of the encoder
// ----------------------------------------------------------------------------
package b32h_pkg;

  localparam int SymBits   = 5;
  localparam int CharBits  = 7;
  localparam int MaxChars  = 3;
  localparam int DigitSyms = 10;

  typedef logic [SymBits-1:0]  sym_t;
  typedef logic [CharBits-1:0] char_t;

  // characters produced by one byte, oldest first
  typedef struct packed {
    sym_t [MaxChars-1:0] syms;
    logic [1:0]          count;
    logic                last;
  } burst_t;

  // '0'-'9' then 'A'-'V'
  function automatic char_t sym_to_char(input sym_t sym);
    char_t c;
    if (sym < sym_t'(DigitSyms)) begin
      c = char_t'(7'd48) + char_t'(sym);
    end else begin
      c = char_t'(7'd55) + char_t'(sym);
    end
    return c;
  endfunction

endpackage

### rtl/b32h_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32h byte and character channels
// valid/ready channels for message bytes in and encoded characters out
// ----------------------------------------------------------------------------
interface b32h_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32h_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

### rtl/b32h_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32h_pack
// joins leftover bits with a new byte and cuts the result into 5-bit symbols
// ----------------------------------------------------------------------------
module b32h_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output b32h_pkg::burst_t  burst
);

  logic [3:0]  leftover_bits;
  logic [2:0]  leftover_count;
  logic [3:0]  leftover_bits_next;
  logic [2:0]  leftover_count_next;

  logic [2:0]  cnt;
  logic [3:0]  keep_mask;
  logic [11:0] acc;
  logic [11:0] win;
  logic [3:0]  total;
  logic        two;
  logic [2:0]  rem;
  logic        pad;

  always_comb begin
    cnt       = (leftover_count > 3'd4) ? 3'd4 : leftover_count;
    keep_mask = (4'b0001 << cnt) - 4'd1;
    acc       = {leftover_bits & keep_mask, data_byte};
    // left justify so the oldest bit sits at the top
    win       = acc << (3'd4 - cnt);
    total     = {1'b0, cnt} + 4'd8;
    two       = (total >= 4'd10);
    rem       = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
    pad       = last_byte && (rem != 3'd0);

    burst.syms[0] = win[11:7];
    burst.syms[1] = win[6:2];   // also the padded char when only one group
    burst.syms[2] = {win[1:0], 3'b000};
    burst.count   = {1'b0, two} + 2'd1 + {1'b0, pad};
    burst.last    = last_byte;

    if (last_byte) begin
      leftover_bits_next  = 4'd0;
      leftover_count_next = 3'd0;
    end else begin
      leftover_bits_next  = acc[3:0] & ((4'b0001 << rem) - 4'd1);
      leftover_count_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
    end else if (load) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

endmodule

### rtl/b32h_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32h_serial
// result register for one byte's symbols, sent one character per transfer
// ----------------------------------------------------------------------------
module b32h_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b32h_pkg::burst_t  burst,
  output logic              busy,
  output logic              done,
  b32h_char_if.source       code
);

  b32h_pkg::burst_t held;
  logic [1:0]       idx;
  logic             final_char;

  assign final_char     = (idx + 2'd1) == held.count;
  assign done           = busy && code.ready && final_char;
  assign code.valid     = busy;
  assign code.code_char = b32h_pkg::sym_to_char(held.syms[idx]);
  assign code.last_char = held.last && final_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && code.ready) begin
      idx  <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end
  end

endmodule

### rtl/base32hex_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32hex_encoder_unit
// unpadded base32hex encoder: one byte in, one to three ascii characters out
// ----------------------------------------------------------------------------
//  channel  dir  payload                       role
//  msg      in   data_byte[7:0], last_byte     message bytes, last marks end
//  code     out  code_char[6:0], last_char     '0'-'9','A'-'V', last marks end
//
//  a byte transfer lands in an input register; the next cycle it is split
//  into symbols and loaded into the result register once that is free, and
//  its characters are then offered from the result register
//  characters leave one per cycle while code is ready; the input register
//  takes a new byte only the cycle after the held byte moves on, so it can
//  take the next byte while the result register still sends characters
//  rst is synchronous, clears the leftover bits and all valid flags and
//  holds msg ready low
//  a stalled output holds the current character; no transfer is dropped
// ----------------------------------------------------------------------------
module base32hex_encoder_unit (
  input  logic         clk,
  input  logic         rst,
  b32h_byte_if.sink    msg,
  b32h_char_if.source  code
);

  // input register
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_last;

  logic             busy;
  logic             done;
  logic             load;
  b32h_pkg::burst_t burst;

  // the input side only sees a registered flag, held off during reset
  assign msg.ready = !rst && !pend_valid;

  // move the held byte on when the result register is empty or emptying
  assign load = pend_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      pend_byte <= msg.data_byte;
      pend_last <= msg.last_byte;
    end
  end

  // symbol split and leftover bit buffer
  b32h_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .data_byte (pend_byte),
    .last_byte (pend_last),
    .burst     (burst)
  );

  // result register and character output
  b32h_serial u_serial (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .burst (burst),
    .busy  (busy),
    .done  (done),
    .code  (code)
  );

endmodule
